>>> hw/rtl/mm4_pkg.sv
// Shared constants, beat types and pipeline control struct for the 4x4 matrix multiply core.
// No dependencies.
package mm4_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int IDX_W     = $clog2(DIM);
    localparam int CELL_W    = $clog2(CELLS);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] a_elem;
        logic signed [DATA_W-1:0] b_elem;
    } mm4_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] product_elem;
        logic                     last_elem;
    } mm4_out_t;

    // flags that travel with each dot-product step
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic row_last;
    } mm4_stage_t;

endpackage

>>> hw/rtl/matrix_4x4_multiply_core.sv
// Top level of the 4x4 signed Q16.16 matrix multiply core.
// Depends on mm4_pkg, mm4_ram, mm4_lane and mm4_merge.

// One beat on start with busy low loads A and B elements at the same position, row-major.
// The beat that completes a frame raises busy; one lane per column of C then steps through k,
// one shared A read per cycle, and each finished row goes to the merge stage, which sends its
// DIM results one per cycle. The last result has last_elem set, and busy drops the cycle
// after it. result_strobe marks each result for one cycle and cannot be held off.
module matrix_4x4_multiply_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mm4_pkg::mm4_in_t  operand,
    output logic              busy,
    output mm4_pkg::mm4_out_t result,
    output logic              result_strobe
);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       accept;
    logic                       load_end;
    logic [mm4_pkg::CELL_W-1:0] load_addr_reg;
    logic [mm4_pkg::CELL_W-1:0] load_addr_next;
    logic [mm4_pkg::IDX_W-1:0]  load_row_reg;
    logic [mm4_pkg::IDX_W-1:0]  load_row_next;
    logic [mm4_pkg::IDX_W-1:0]  load_col_reg;
    logic [mm4_pkg::IDX_W-1:0]  load_col_next;

    logic                       seq_active_reg;
    logic                       seq_active_next;
    logic [mm4_pkg::CELL_W-1:0] seq_addr_reg;
    logic [mm4_pkg::CELL_W-1:0] seq_addr_next;
    logic [mm4_pkg::IDX_W-1:0]  seq_k_reg;
    logic [mm4_pkg::IDX_W-1:0]  seq_k_next;
    logic [mm4_pkg::IDX_W-1:0]  seq_r_reg;
    logic [mm4_pkg::IDX_W-1:0]  seq_r_next;
    logic                       seq_k_end;

    mm4_pkg::mm4_stage_t        st0;
    mm4_pkg::mm4_stage_t        st1_reg;
    mm4_pkg::mm4_stage_t        st2_reg;
    mm4_pkg::mm4_stage_t        st3_reg;

    logic [mm4_pkg::DATA_W-1:0] a_rd_data;
    logic [mm4_pkg::DATA_W-1:0] lane_elem [mm4_pkg::DIM];

    assign accept    = start & ~busy_reg;
    assign load_end  = (load_addr_reg == mm4_pkg::CELL_W'(mm4_pkg::CELLS - 1));
    assign seq_k_end = (seq_k_reg == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1));

    always_comb
    begin
        load_addr_next = load_addr_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        busy_next      = busy_reg;
        if (accept)
        begin
            if (load_end)
            begin
                load_addr_next = '0;
                load_row_next  = '0;
                load_col_next  = '0;
                busy_next      = 1'b1;
            end
            else
            begin
                load_addr_next = load_addr_reg + 1'b1;
                if (load_col_reg == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1))
                begin
                    load_col_next = '0;
                    load_row_next = load_row_reg + 1'b1;
                end
                else
                begin
                    load_col_next = load_col_reg + 1'b1;
                end
            end
        end
        else if (result_strobe & result.last_elem)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        seq_active_next = seq_active_reg;
        seq_addr_next   = seq_addr_reg;
        seq_k_next      = seq_k_reg;
        seq_r_next      = seq_r_reg;
        if (accept & load_end)
        begin
            seq_active_next = 1'b1;
            seq_addr_next   = '0;
            seq_k_next      = '0;
            seq_r_next      = '0;
        end
        else if (seq_active_reg)
        begin
            if (seq_addr_reg == mm4_pkg::CELL_W'(mm4_pkg::CELLS - 1))
            begin
                seq_active_next = 1'b0;
            end
            seq_addr_next = seq_addr_reg + 1'b1;
            if (seq_k_end)
            begin
                seq_k_next = '0;
                seq_r_next = seq_r_reg + 1'b1;
            end
            else
            begin
                seq_k_next = seq_k_reg + 1'b1;
            end
        end
    end

    assign st0.valid    = seq_active_reg;
    assign st0.first    = (seq_k_reg == '0);
    assign st0.last     = seq_k_end;
    assign st0.row_last = (seq_r_reg == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            load_addr_reg  <= '0;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            seq_active_reg <= 1'b0;
            seq_addr_reg   <= '0;
            seq_k_reg      <= '0;
            seq_r_reg      <= '0;
            st1_reg        <= '0;
            st2_reg        <= '0;
            st3_reg        <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            load_addr_reg  <= load_addr_next;
            load_row_reg   <= load_row_next;
            load_col_reg   <= load_col_next;
            seq_active_reg <= seq_active_next;
            seq_addr_reg   <= seq_addr_next;
            seq_k_reg      <= seq_k_next;
            seq_r_reg      <= seq_r_next;
            st1_reg        <= st0;
            st2_reg        <= st1_reg;
            st3_reg        <= st2_reg;
        end
    end

    mm4_ram #(
        .WIDTH (mm4_pkg::DATA_W),
        .DEPTH (mm4_pkg::CELLS)
    ) u_a_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (load_addr_reg),
        .wr_data (operand.a_elem),
        .rd_addr (seq_addr_reg),
        .rd_data (a_rd_data)
    );

    for (genvar c = 0; c < mm4_pkg::DIM; c++)
    begin : g_lane
        mm4_lane u_lane (
            .clk          (clk),
            .wr_en        (accept && (load_col_reg == mm4_pkg::IDX_W'(c))),
            .wr_addr      (load_row_reg),
            .wr_data      (operand.b_elem),
            .rd_addr      (seq_k_reg),
            .a_data       (a_rd_data),
            .stage        (st2_reg),
            .product_elem (lane_elem[c])
        );
    end

    mm4_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (st3_reg),
        .lane_elem     (lane_elem),
        .result        (result),
        .result_strobe (result_strobe)
    );

    assign busy = busy_reg;

endmodule

>>> hw/rtl/mm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/mm4_lane.sv
// One dot-product lane: holds one column of B, multiplies, accumulates, shifts and saturates.
// Depends on mm4_pkg and mm4_ram.
module mm4_lane (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [mm4_pkg::IDX_W-1:0]   wr_addr,
    input  logic [mm4_pkg::DATA_W-1:0]  wr_data,
    input  logic [mm4_pkg::IDX_W-1:0]   rd_addr,
    input  logic [mm4_pkg::DATA_W-1:0]  a_data,
    input  mm4_pkg::mm4_stage_t         stage,
    output logic [mm4_pkg::DATA_W-1:0]  product_elem
);

    logic [mm4_pkg::DATA_W-1:0]        b_data;
    logic signed [mm4_pkg::DATA_W-1:0] a_s;
    logic signed [mm4_pkg::DATA_W-1:0] b_s;
    logic signed [mm4_pkg::PROD_W-1:0] product_reg;
    logic signed [mm4_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mm4_pkg::ACC_W-1:0]  acc_next;
    logic signed [mm4_pkg::ACC_W-1:0]  shifted;
    logic [mm4_pkg::ACC_W-mm4_pkg::DATA_W:0] upper;
    logic                              fits;

    mm4_ram #(
        .WIDTH (mm4_pkg::DATA_W),
        .DEPTH (mm4_pkg::DIM)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (b_data)
    );

    assign a_s = $signed(a_data);
    assign b_s = $signed(b_data);

    always_comb
    begin
        if (stage.first)
        begin
            acc_next = mm4_pkg::ACC_W'(product_reg);
        end
        else
        begin
            acc_next = acc_reg + mm4_pkg::ACC_W'(product_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= a_s * b_s;
        if (stage.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign shifted = acc_reg >>> mm4_pkg::FRAC_BITS;
    assign upper   = shifted[mm4_pkg::ACC_W-1:mm4_pkg::DATA_W-1];
    assign fits    = (&upper) | ~(|upper);

    always_comb
    begin
        if (fits)
        begin
            product_elem = shifted[mm4_pkg::DATA_W-1:0];
        end
        else if (acc_reg[mm4_pkg::ACC_W-1])
        begin
            product_elem = mm4_pkg::SAT_MIN;
        end
        else
        begin
            product_elem = mm4_pkg::SAT_MAX;
        end
    end

endmodule

>>> hw/rtl/mm4_merge.sv
// Merge stage: captures one finished row from all lanes and sends it out one beat per cycle.
// Depends on mm4_pkg.
module mm4_merge (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mm4_pkg::mm4_stage_t        stage,
    input  logic [mm4_pkg::DATA_W-1:0] lane_elem [mm4_pkg::DIM],
    output mm4_pkg::mm4_out_t          result,
    output logic                       result_strobe
);

    logic [mm4_pkg::DATA_W-1:0] hold_reg [mm4_pkg::DIM];
    logic                       row_last_reg;
    logic [mm4_pkg::IDX_W-1:0]  cnt_reg;
    logic [mm4_pkg::IDX_W-1:0]  cnt_next;
    logic                       active_reg;
    logic                       active_next;
    logic                       cap;
    logic                       cnt_end;
    mm4_pkg::mm4_out_t          result_reg;
    logic                       strobe_reg;

    assign cap     = stage.valid & stage.last;
    assign cnt_end = (cnt_reg == mm4_pkg::IDX_W'(mm4_pkg::DIM - 1));

    always_comb
    begin
        cnt_next    = cnt_reg;
        active_next = active_reg;
        if (cap)
        begin
            cnt_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (cnt_end)
            begin
                cnt_next    = '0;
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            hold_reg     <= lane_elem;
            row_last_reg <= stage.row_last;
        end
        result_reg.product_elem <= hold_reg[cnt_reg];
        result_reg.last_elem    <= row_last_reg & cnt_end;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

>>> tb/tb.sv
// Self-checking bench for matrix_4x4_multiply_core: loads A/B frames beat by beat and
// compares every product element against a Q16.16 dot-product predictor or a typed row's value.
// Depends on mm4_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mm4_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int N_DIRECTED    = 5;
    localparam int FRAMES_PHASE  = 6;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              typed;
        logic [DATA_W-1:0] prod;
    } frame_row_t;

    // typed rows fill both matrices with one value, so every element of C is the same
    localparam frame_row_t DIRECTED_FRAMES [N_DIRECTED] = '{
        '{SAT_MAX,       SAT_MAX,       1'b1, SAT_MAX},
        '{SAT_MIN,       SAT_MAX,       1'b1, SAT_MIN},
        '{SAT_MIN,       SAT_MIN,       1'b1, SAT_MAX},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0000_0000}
    };

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    mm4_in_t  operand = '0;
    logic     busy;
    mm4_out_t result;
    logic     result_strobe;

    logic signed [DATA_W-1:0] a_mat [CELLS];
    logic signed [DATA_W-1:0] b_mat [CELLS];
    int       load_idx = 0;
    mm4_out_t pending_products [$];
    int       errors   = 0;
    int       idle_pct = 0;
    int       cycles   = 0;

    matrix_4x4_multiply_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operand       (operand),
        .busy          (busy),
        .result        (result),
        .result_strobe (result_strobe)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("MISMATCH @%0t %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    // exact products, wide sum, floor shift, saturate
    function automatic logic [DATA_W-1:0] dot_product_cell(input int r, input int c);
        logic signed [ACC_W-1:0] acc;
        longint                  shifted;
        acc = '0;
        for (int k = 0; k < DIM; k++)
            acc += longint'(a_mat[r*DIM+k]) * longint'(b_mat[k*DIM+c]);
        shifted = longint'(acc >>> FRAC_BITS);
        if (shifted > longint'(SAT_MAX))
            return SAT_MAX;
        if (shifted < -longint'(SAT_MAX) - 1)
            return SAT_MIN;
        return shifted[DATA_W-1:0];
    endfunction

    task automatic record_beat(input mm4_in_t beat, input logic typed,
                               input logic [DATA_W-1:0] typed_prod);
        mm4_out_t want;
        a_mat[load_idx] = beat.a_elem;
        b_mat[load_idx] = beat.b_elem;
        if (load_idx == CELLS - 1)
        begin
            load_idx = 0;
            for (int r = 0; r < DIM; r++)
                for (int c = 0; c < DIM; c++)
                begin
                    want.product_elem = typed ? typed_prod : dot_product_cell(r, c);
                    want.last_elem    = (r == DIM - 1) && (c == DIM - 1);
                    pending_products.push_back(want);
                end
        end
        else
            load_idx++;
    endtask

    task automatic send_beat(input mm4_in_t beat, input logic typed,
                             input logic [DATA_W-1:0] typed_prod);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        operand <= beat;
        do
            @(posedge clk);
        while (busy);
        record_beat(beat, typed, typed_prod);
    endtask

    function automatic logic [DATA_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin : result_monitor
        mm4_out_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_products.size() == 0)
                flag_mismatch("result beat with nothing pending", result.product_elem, '0);
            else
            begin
                want = pending_products.pop_front();
                if (result.product_elem !== want.product_elem)
                    flag_mismatch("product_elem", result.product_elem, want.product_elem);
                if (result.last_elem !== want.last_elem)
                    flag_mismatch("last_elem", {31'b0, result.last_elem},
                                  {31'b0, want.last_elem});
            end
        end
    end

    initial
    begin : stimulus
        mm4_in_t    beat;
        frame_row_t row;
        int         n_frames;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 10;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED_FRAMES[i];
            for (int idx = 0; idx < CELLS; idx++)
            begin
                beat.a_elem = row.typed ? row.a : row.a ^ idx;
                beat.b_elem = row.typed ? row.b : row.b + (idx << 12);
                send_beat(beat, row.typed, row.prod);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 10 : (phase == 1) ? 55 : 0;
            n_frames = FRAMES_PHASE;
            for (int f = 0; f < n_frames; f++)
                for (int idx = 0; idx < CELLS; idx++)
                begin
                    beat.a_elem = rand_elem();
                    beat.b_elem = rand_elem();
                    send_beat(beat, 1'b0, '0);
                end
        end
        start <= 1'b0;

        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (CELLS + 8) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
